@@ sv/isf_pkg.sv @@
`timescale 1ns / 1ps
// isf_pkg: shared types and constants for the image spatial frequency block.
// No dependencies; imported by isf_ctrl, isf_datapath and the top level.

package isf_pkg;

  // Field widths fixed by the interface
  localparam int PIX_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int FREQ_W   = 16;
  localparam int SF_W     = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Quotient of sum*65536/N is below 2*65025*65536 < 2^33
  localparam int QUO_W  = 33;
  // Root of a QUO_W-bit value
  localparam int ROOT_W = 17;
  // Working width of the root unit (partial result plus bit)
  localparam int SQ_W   = QUO_W + 1;

  // Which sum is being reduced
  localparam logic [1:0] SEL_ROW = 2'd0;
  localparam logic [1:0] SEL_COL = 2'd1;
  localparam logic [1:0] SEL_SUM = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       pix_take;    // pixel transaction: latch pixel, read line store
    logic       pix_acc;     // accumulate differences, step counters
    logic       div_start;   // load divider with selected sum
    logic       sqrt_start;  // load root unit with quotient
    logic       res_store;   // keep finished root in staging
    logic       res_load;    // move staged results into output register
    logic [1:0] sel;         // sum selector
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_last;  // current pixel closes the frame
    logic div_done;
    logic sqrt_done;
    logic out_busy;    // output register holds an untaken result
  } sts_t;

endpackage

@@ sv/isf_ctrl.sv @@
`timescale 1ns / 1ps
// isf_ctrl: sequencing state machine for the spatial frequency block.
// Depends on isf_pkg (cmd_t, sts_t, selector codes).

module isf_ctrl import isf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pixel_valid_i,
  output logic pixel_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ACC      = 3'd1;
  localparam logic [2:0] S_DIV_ST   = 3'd2;
  localparam logic [2:0] S_DIV_RUN  = 3'd3;
  localparam logic [2:0] S_SQ_ST    = 3'd4;
  localparam logic [2:0] S_SQ_RUN   = 3'd5;
  localparam logic [2:0] S_OUT_WAIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  // Next state and command decode
  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    cmd_o     = '0;
    cmd_o.sel = sel_q;
    case (state_q)
      S_IDLE: begin
        if (pixel_valid_i) begin
          cmd_o.pix_take = 1'b1;
          state_d        = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.pix_acc = 1'b1;
        if (sts_i.frame_last) begin
          sel_d   = SEL_ROW;
          state_d = S_DIV_ST;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV_ST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts_i.div_done) begin
          state_d = S_SQ_ST;
        end
      end
      S_SQ_ST: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        if (sts_i.sqrt_done) begin
          cmd_o.res_store = 1'b1;
          if (sel_q == SEL_SUM) begin
            state_d = S_OUT_WAIT;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_DIV_ST;
          end
        end
      end
      S_OUT_WAIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign pixel_ready_o = (state_q == S_IDLE);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= SEL_ROW;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Checks
  sel_range_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q != 2'd3)
    else $error("isf_ctrl: selector out of range");

  frame_end_seq_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) && sts_i.frame_last |=> cmd_o.div_start && (sel_q == SEL_ROW))
    else $error("isf_ctrl: frame end did not start row reduction");

  last_root_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_store && (sel_q == SEL_SUM) |=> (state_q == S_OUT_WAIT))
    else $error("isf_ctrl: third root did not lead to output");

endmodule

@@ sv/isf_datapath.sv @@
`timescale 1ns / 1ps
// isf_datapath: line store, difference accumulators, bit-serial divider,
// digit-by-digit root unit and output register. Depends on isf_pkg.

module isf_datapath import isf_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW     = $clog2(MAX_WIDTH + 1),
  localparam int HW     = $clog2(MAX_HEIGHT + 1),
  localparam int LW     = $clog2(MAX_WIDTH),
  localparam int LH     = $clog2(MAX_HEIGHT),
  localparam int NW     = WW + HW,
  localparam int SUM_W  = 2 * PIX_W + NW,
  localparam int DW     = SUM_W + 1 + 16,
  localparam int DCW    = $clog2(DW + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [WW-1:0]     w_i,
  input  logic [HW-1:0]     h_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [FREQ_W-1:0] row_freq_o,
  output logic [FREQ_W-1:0] col_freq_o,
  output logic [SF_W-1:0]   spatial_freq_o
);

  // Pixel path
  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] above_q;
  logic [PIX_W-1:0] left_q, left_d;
  logic [LW-1:0]    col_q, col_d;
  logic [LH-1:0]    row_q, row_d;
  logic [SUM_W-1:0] row_sum_q, row_sum_d;
  logic [SUM_W-1:0] col_sum_q, col_sum_d;
  logic [NW-1:0]    n_q;
  logic             last_col, last_row;
  logic [PIX_W-1:0] diff_l, diff_a;
  logic [2*PIX_W-1:0] sq_l, sq_a;

  // Divider
  logic [DW-1:0]    dvd_q;
  logic [NW-1:0]    rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DCW-1:0]   dcnt_q;
  logic [NW:0]      rem_trial;
  logic             rem_ge;
  logic [SUM_W:0]   sum_sel;

  // Root unit
  logic [QUO_W-1:0] x_q;
  logic [SQ_W-1:0]  root_q;
  logic [SQ_W-1:0]  bit_q;
  logic [SQ_W-1:0]  sq_trial;
  logic             sq_ge;

  // Staging and output
  logic [FREQ_W-1:0] row_stage_q, col_stage_q;
  logic [FREQ_W-1:0] row_freq_q, col_freq_q;
  logic [SF_W-1:0]   sf_q;
  logic              res_valid_q;

  // Line store: registered read on the pixel transaction, write on accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take) begin
      pix_q   <= pixel_i;
      above_q <= line_mem[col_q];
    end
    if (cmd_i.pix_acc) begin
      line_mem[col_q] <= pix_q;
    end
  end

  // Row and frame end detection
  assign last_col = (WW'(col_q) + WW'(1)) >= w_i;
  assign last_row = (HW'(row_q) + HW'(1)) >= h_i;

  // Squared differences to left and above neighbours
  assign diff_l = (pix_q >= left_q) ? pix_q - left_q : left_q - pix_q;
  assign diff_a = (pix_q >= above_q) ? pix_q - above_q : above_q - pix_q;
  assign sq_l   = (2*PIX_W)'(diff_l) * (2*PIX_W)'(diff_l);
  assign sq_a   = (2*PIX_W)'(diff_a) * (2*PIX_W)'(diff_a);

  // Accumulate and step counters
  always_comb begin
    left_d    = left_q;
    col_d     = col_q;
    row_d     = row_q;
    row_sum_d = row_sum_q;
    col_sum_d = col_sum_q;
    if (cmd_i.pix_acc) begin
      if (col_q != '0) begin
        row_sum_d = row_sum_q + SUM_W'(sq_l);
      end
      if (row_q != '0) begin
        col_sum_d = col_sum_q + SUM_W'(sq_a);
      end
      if (last_col) begin
        col_d  = '0;
        left_d = '0;
        row_d  = last_row ? '0 : row_q + LH'(1);
      end else begin
        col_d  = col_q + LW'(1);
        left_d = pix_q;
      end
    end
    // sums are free once the last reduction has taken its operand
    if (cmd_i.div_start && (cmd_i.sel == SEL_SUM)) begin
      row_sum_d = '0;
      col_sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
      col_sum_q <= '0;
    end else begin
      left_q    <= left_d;
      col_q     <= col_d;
      row_q     <= row_d;
      row_sum_q <= row_sum_d;
      col_sum_q <= col_sum_d;
    end
  end

  // Pixel count of the frame, taken on the closing pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_acc && last_col && last_row) begin
      n_q <= NW'(w_i) * NW'(h_i);
    end
  end

  // Dividend selection
  always_comb begin
    case (cmd_i.sel)
      SEL_ROW: sum_sel = {1'b0, row_sum_q};
      SEL_COL: sum_sel = {1'b0, col_sum_q};
      SEL_SUM: sum_sel = (SUM_W + 1)'(row_sum_q) + (SUM_W + 1)'(col_sum_q);
      default: sum_sel = '0;
    endcase
  end

  // Restoring divider, one quotient bit per cycle
  assign rem_trial = {rem_q, dvd_q[DW-1]};
  assign rem_ge    = rem_trial >= {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= {sum_sel, 16'd0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (dcnt_q != '0) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= rem_ge ? NW'(rem_trial - {1'b0, n_q}) : NW'(rem_trial);
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCW'(DW);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DCW'(1);
    end
  end

  // Integer root, two radicand bits per cycle
  assign sq_trial = root_q + bit_q;
  assign sq_ge    = SQ_W'(x_q) >= sq_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      x_q    <= quo_q;
      root_q <= '0;
    end else if (bit_q != '0) begin
      if (sq_ge) begin
        x_q    <= QUO_W'(SQ_W'(x_q) - sq_trial);
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      bit_q <= SQ_W'(1) << (QUO_W - 1);
    end else begin
      bit_q <= bit_q >> 2;
    end
  end

  // Staging of the first two roots and load of the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_store) begin
      case (cmd_i.sel)
        SEL_ROW: row_stage_q <= FREQ_W'(root_q);
        SEL_COL: col_stage_q <= FREQ_W'(root_q);
        default: ;
      endcase
    end
    if (cmd_i.res_load) begin
      row_freq_q <= row_stage_q;
      col_freq_q <= col_stage_q;
      sf_q       <= SF_W'(root_q);
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign sts_o.frame_last = last_col && last_row;
  assign sts_o.div_done   = (dcnt_q == '0);
  assign sts_o.sqrt_done  = (bit_q == '0);
  assign sts_o.out_busy   = res_valid_q && !res_ready_i;

  assign res_valid_o    = res_valid_q;
  assign row_freq_o     = row_freq_q;
  assign col_freq_o     = col_freq_q;
  assign spatial_freq_o = sf_q;

  // Checks
  counters_clear_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pix_acc && last_col && last_row |=> (col_q == '0) && (row_q == '0))
    else $error("isf_datapath: counters not cleared at frame end");

  rem_below_n_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcnt_q != '0) |-> ({1'b0, rem_q} < {1'b0, n_q}))
    else $error("isf_datapath: divider remainder not below divisor");

  root_bit_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bit_q))
    else $error("isf_datapath: root unit bit not one-hot");

  no_overlap_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_start |-> (dcnt_q == '0))
    else $error("isf_datapath: root started while divider busy");

  load_valid_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> res_valid_o)
    else $error("isf_datapath: loaded result not presented");

endmodule

@@ sv/image_spatial_frequency_top.sv @@
`timescale 1ns / 1ps
// Spatial frequency top: each pixel is taken in a transaction and then accumulated,
// as the line store read is registered; no new pixel is taken until then. On the last
// pixel of a frame the result comes from three bit-serial divides and roots in one
// shared unit pair (DW = dividend bits, 59 at 4096x4096); pixel ready returns with
// the result, later only while an earlier result is still untaken.
// Reset clears counters, sums and control; width and height reset to 4096.

module image_spatial_frequency_top import isf_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 pixel_valid_i,
  output logic                 pixel_ready_o,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [FREQ_W-1:0]    row_freq_o,
  output logic [FREQ_W-1:0]    col_freq_o,
  output logic [SF_W-1:0]      spatial_freq_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  isf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  isf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_i        (pixel_i),
    .w_i            (w_eff),
    .h_i            (h_eff),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .row_freq_o     (row_freq_o),
    .col_freq_o     (col_freq_o),
    .spatial_freq_o (spatial_freq_o)
  );

endmodule
